>>> rtl/polar_cartesian_converter_assert.svh
// Assertion macros for the polar/Cartesian converter.
// Both sample on the rising edge of clk and are off while arst_n is low.
`ifndef POLAR_CARTESIAN_CONVERTER_ASSERT_SVH
`define POLAR_CARTESIAN_CONVERTER_ASSERT_SVH

// Same-cycle implication
`define PCC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define PCC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/pcc_pkg.sv
package pcc_pkg;

	// Datapath widths: x/y carry 16 fraction bits, z is 1/64 degree with 16 fraction bits
	localparam int FRAC = 16;
	localparam int DW   = 34;
	localparam int ZW   = 32;
	localparam int MAX_ITER = 24;

	// Gain compensation multiply: x split into a signed high and unsigned low part
	localparam int LOW_BITS = 17;
	localparam int HIW      = DW - LOW_BITS;
	localparam int KW       = 31;
	localparam int PHW      = HIW + KW;
	localparam int PLW      = LOW_BITS + 1 + KW;
	localparam int SW       = 66;
	localparam int OSHIFT   = 30 + FRAC;
	localparam int QW       = SW - OSHIFT;

	localparam logic signed [KW-1:0] K_Q30 = 31'sd652032874;

	// Angles in 1/64 degree
	localparam logic signed [15:0] DEG90  = 16'sd5760;
	localparam logic signed [15:0] DEG180 = 16'sd11520;
	localparam logic signed [15:0] DEG360 = 16'sd23040;
	localparam logic signed [ZW-1:0] Z_DEG90 = 32'sd377487360;

	typedef struct packed {
		logic                 mode;
		logic                 origin;
		logic signed [DW-1:0] x;
		logic signed [DW-1:0] y;
		logic signed [ZW-1:0] z;
	} pcc_data_t;

	// Arctangent of 2^-i in 1/64 degree with 16 fraction bits
	function automatic logic signed [ZW-1:0] atan_lut(input int idx);
		logic signed [ZW-1:0] v;
		case (idx)
			0:  v = 32'sd188743680;
			1:  v = 32'sd111421900;
			2:  v = 32'sd58872272;
			3:  v = 32'sd29884485;
			4:  v = 32'sd15000234;
			5:  v = 32'sd7507429;
			6:  v = 32'sd3754631;
			7:  v = 32'sd1877430;
			8:  v = 32'sd938729;
			9:  v = 32'sd469366;
			10: v = 32'sd234683;
			11: v = 32'sd117342;
			12: v = 32'sd58671;
			13: v = 32'sd29335;
			14: v = 32'sd14668;
			15: v = 32'sd7334;
			16: v = 32'sd3667;
			17: v = 32'sd1833;
			18: v = 32'sd917;
			19: v = 32'sd458;
			20: v = 32'sd229;
			21: v = 32'sd115;
			22: v = 32'sd57;
			23: v = 32'sd29;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/pcc_stage.sv
module pcc_stage
	import pcc_pkg::*;
#(
	parameter int SHIFT = 0
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic      vld_i,
	input  pcc_data_t d_i,
	output logic      vld_o,
	output pcc_data_t d_o
);

	localparam logic signed [ZW-1:0] ATAN = atan_lut(SHIFT);

	logic signed [DW-1:0] xc, yc, dx, dy;
	logic signed [ZW-1:0] zc;
	logic                 neg;
	pcc_data_t            nxt;
	logic                 vld_q;
	pcc_data_t            d_q;

	// One micro-rotation: vectoring steers on y, rotation steers on z
	always_comb begin
		xc  = d_i.x;
		yc  = d_i.y;
		zc  = d_i.z;
		dx  = yc >>> SHIFT;
		dy  = xc >>> SHIFT;
		neg = d_i.mode ? ~zc[ZW-1] : yc[DW-1];
		nxt = d_i;
		if (neg) begin
			nxt.x = xc - dx;
			nxt.y = yc + dy;
			nxt.z = zc - ATAN;
		end else begin
			nxt.x = xc + dx;
			nxt.y = yc - dy;
			nxt.z = zc + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (en) begin
			vld_q <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q <= nxt;
		end
	end

	assign vld_o = vld_q;
	assign d_o   = d_q;

endmodule

>>> rtl/polar_cartesian_converter.sv
// Polar/Cartesian converter, gain-compensated CORDIC, one micro-rotation per stage.
// Input channel (in_valid/in_ready): mode, x_in, y_in, radius_in, angle_in.
//   mode 0 converts (x_in, y_in) to radius_out and angle_out (1/64 degree);
//   mode 1 converts (radius_in, angle_in) to saturated x_out and y_out.
//   The fields not used by a mode come out as zero.
// Output channel (out_valid/out_ready): radius_out, angle_out, x_out, y_out.
// Pipeline: one setup stage, ITERATIONS rotation stages, one multiply stage, one
//   rounding/saturation stage that is the output register; ITERATIONS above
//   the 24-entry arctangent table counts as 24.
// Throughput: one item per cycle while out_ready is high; every stage has its own valid bit.
// Stalls: each stage takes new data when it is empty or the stage after it
//   moves, so a held result blocks only the stages that are full behind it
//   and bubbles are squeezed out; nothing is dropped or repeated.
// Reset: arst_n clears all valid bits; the pipeline comes up empty.
module polar_cartesian_converter
	import pcc_pkg::*;
#(
	parameter int ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               mode,
	input  logic signed [15:0] x_in,
	input  logic signed [15:0] y_in,
	input  logic        [14:0] radius_in,
	input  logic signed [14:0] angle_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic        [15:0] radius_out,
	output logic signed [14:0] angle_out,
	output logic signed [15:0] x_out,
	output logic signed [15:0] y_out
);

	// Rotation count, limited to the arctangent table
	localparam int NROT = (ITERATIONS > MAX_ITER) ? MAX_ITER : ITERATIONS;
	localparam int NSTG = NROT + 3;

	logic [NSTG-1:0] vld;
	logic [NSTG:0]   adv;

	// Per-stage advance: a stage loads when empty or when its successor moves
	assign adv[NSTG] = out_ready;
	for (genvar k = 0; k < NSTG; k++) begin : g_adv
		assign adv[k] = ~vld[k] | adv[k+1];
	end
	assign in_ready = adv[0];

	// ---------------- setup stage ----------------
	logic signed [DW-1:0] xi_w, yi_w, r_w;
	logic signed [15:0]   a_w;
	pcc_data_t            pre_d;
	logic                 pre_vld_s1;
	pcc_data_t            pre_d_s1;

	always_comb begin
		xi_w = $signed({{(DW-16-FRAC){x_in[15]}}, x_in, {FRAC{1'b0}}});
		yi_w = $signed({{(DW-16-FRAC){y_in[15]}}, y_in, {FRAC{1'b0}}});
		r_w  = $signed({{(DW-15-FRAC){1'b0}}, radius_in, {FRAC{1'b0}}});
		a_w  = 16'(angle_in);
		pre_d        = '0;
		pre_d.mode   = mode;
		pre_d.origin = (x_in == 16'sd0) && (y_in == 16'sd0);
		if (!mode) begin
			// left half plane: pre-rotate by -90 (y >= 0) or +90 degrees
			pre_d.x = xi_w;
			pre_d.y = yi_w;
			pre_d.z = '0;
			if (x_in[15]) begin
				if (!y_in[15]) begin
					pre_d.x = yi_w;
					pre_d.y = -xi_w;
					pre_d.z = Z_DEG90;
				end else begin
					pre_d.x = -yi_w;
					pre_d.y = xi_w;
					pre_d.z = -Z_DEG90;
				end
			end
		end else begin
			// wrap by 360 degrees, then fold the outer quadrants
			if (a_w > DEG180) begin
				a_w = a_w - DEG360;
			end
			if (a_w < -DEG180) begin
				a_w = a_w + DEG360;
			end
			if (a_w > DEG90) begin
				pre_d.x = '0;
				pre_d.y = r_w;
				a_w     = a_w - DEG90;
			end else if (a_w < -DEG90) begin
				pre_d.x = '0;
				pre_d.y = -r_w;
				a_w     = a_w + DEG90;
			end else begin
				pre_d.x = r_w;
				pre_d.y = '0;
			end
			pre_d.z = $signed({a_w, {FRAC{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pre_vld_s1 <= 1'b0;
		end else if (adv[0]) begin
			pre_vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[0]) begin
			pre_d_s1 <= pre_d;
		end
	end

	assign vld[0] = pre_vld_s1;

	// ---------------- CORDIC rotation stages ----------------
	pcc_data_t rot_d [0:NROT];
	logic      rot_v [0:NROT];

	assign rot_d[0] = pre_d_s1;
	assign rot_v[0] = pre_vld_s1;

	for (genvar i = 0; i < NROT; i++) begin : g_rot
		pcc_stage #(
			.SHIFT (i)
		) u_stage (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (adv[i+1]),
			.vld_i  (rot_v[i]),
			.d_i    (rot_d[i]),
			.vld_o  (rot_v[i+1]),
			.d_o    (rot_d[i+1])
		);
		assign vld[i+1] = rot_v[i+1];
	end

	// ---------------- gain multiply stage ----------------
	pcc_data_t               fin;
	logic signed [HIW-1:0]   xh_w, yh_w;
	logic signed [LOW_BITS:0] xl_w, yl_w;
	logic signed [ZW-1:0]    zr_w;
	logic signed [15:0]      ang_w;
	logic [14:0]             ang_c;

	always_comb begin
		fin   = rot_d[NROT];
		xh_w  = fin.x[DW-1:LOW_BITS];
		yh_w  = fin.y[DW-1:LOW_BITS];
		xl_w  = $signed({1'b0, fin.x[LOW_BITS-1:0]});
		yl_w  = $signed({1'b0, fin.y[LOW_BITS-1:0]});
		// round to nearest, ties up, then clamp to +-180 degrees
		zr_w  = fin.z + $signed(ZW'(1 << (FRAC - 1)));
		ang_w = zr_w[ZW-1:FRAC];
		if (ang_w > DEG180) begin
			ang_c = 15'(DEG180);
		end else if (ang_w < -DEG180) begin
			ang_c = 15'(-DEG180);
		end else begin
			ang_c = ang_w[14:0];
		end
	end

	logic                  mul_vld_s2;
	logic                  mul_mode_s2;
	logic                  mul_origin_s2;
	logic signed [PHW-1:0] mul_xh_s2, mul_yh_s2;
	logic signed [PLW-1:0] mul_xl_s2, mul_yl_s2;
	logic        [14:0]    mul_ang_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_vld_s2 <= 1'b0;
		end else if (adv[NROT+1]) begin
			mul_vld_s2 <= rot_v[NROT];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NROT+1]) begin
			mul_mode_s2   <= fin.mode;
			mul_origin_s2 <= fin.origin;
			mul_xh_s2     <= xh_w * K_Q30;
			mul_xl_s2     <= xl_w * K_Q30;
			mul_yh_s2     <= yh_w * K_Q30;
			mul_yl_s2     <= yl_w * K_Q30;
			mul_ang_s2    <= ang_c;
		end
	end

	assign vld[NROT+1] = mul_vld_s2;

	// ---------------- round, saturate and select ----------------
	logic signed [SW-1:0] sx_w, sy_w;
	logic signed [QW-1:0] qx_w, qy_w;
	logic        [15:0]   rad_c;
	logic signed [15:0]   xo_c, yo_c;

	always_comb begin
		sx_w = (SW'(mul_xh_s2) <<< LOW_BITS) + SW'(mul_xl_s2)
			+ $signed(SW'(1) << (OSHIFT - 1));
		sy_w = (SW'(mul_yh_s2) <<< LOW_BITS) + SW'(mul_yl_s2)
			+ $signed(SW'(1) << (OSHIFT - 1));
		qx_w = sx_w[SW-1:OSHIFT];
		qy_w = sy_w[SW-1:OSHIFT];
		if (qx_w < 0) begin
			rad_c = '0;
		end else if (qx_w > $signed(QW'(65535))) begin
			rad_c = 16'hFFFF;
		end else begin
			rad_c = qx_w[15:0];
		end
		if (qx_w < $signed(-QW'(32768))) begin
			xo_c = 16'sh8000;
		end else if (qx_w > $signed(QW'(32767))) begin
			xo_c = 16'sh7FFF;
		end else begin
			xo_c = qx_w[15:0];
		end
		if (qy_w < $signed(-QW'(32768))) begin
			yo_c = 16'sh8000;
		end else if (qy_w > $signed(QW'(32767))) begin
			yo_c = 16'sh7FFF;
		end else begin
			yo_c = qy_w[15:0];
		end
	end

	logic               out_vld_s3;
	logic        [15:0] rad_s3;
	logic signed [14:0] ang_s3;
	logic signed [15:0] xo_s3, yo_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_s3 <= 1'b0;
		end else if (adv[NROT+2]) begin
			out_vld_s3 <= mul_vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[NROT+2]) begin
			if (!mul_mode_s2) begin
				rad_s3 <= mul_origin_s2 ? 16'd0 : rad_c;
				ang_s3 <= mul_origin_s2 ? 15'sd0 : $signed(mul_ang_s2);
				xo_s3  <= '0;
				yo_s3  <= '0;
			end else begin
				rad_s3 <= '0;
				ang_s3 <= '0;
				xo_s3  <= xo_c;
				yo_s3  <= yo_c;
			end
		end
	end

	assign vld[NROT+2] = out_vld_s3;

	assign out_valid  = out_vld_s3;
	assign radius_out = rad_s3;
	assign angle_out  = ang_s3;
	assign x_out      = xo_s3;
	assign y_out      = yo_s3;

	// ---------------- assertions ----------------
`include "polar_cartesian_converter_assert.svh"

	`PCC_ASSERT_NOW(a_free_out_ready, !out_valid, in_ready, "empty output stage but input stalled")
	`PCC_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, pre_vld_s1, "accepted item not in setup stage")
	`PCC_ASSERT_NOW(a_mode_fields, out_valid, (radius_out == 16'd0 && angle_out == 15'sd0) || (x_out == 16'sd0 && y_out == 16'sd0), "both polar and Cartesian fields nonzero")
	`PCC_ASSERT_NOW(a_angle_range, out_valid, angle_out >= -15'sd11520 && angle_out <= 15'sd11520, "angle_out outside +-180 degrees")

endmodule

>>> test/polar_cartesian_converter_tb.sv
`timescale 1ns / 1ps

module polar_cartesian_converter_tb;

	localparam int ROT_STAGES = 16;
	localparam int ROT_USED   = (ROT_STAGES > 24) ? 24 : ROT_STAGES;
	localparam int LATENCY    = ROT_STAGES + 3;

	typedef enum logic {TO_POLAR = 1'b0, TO_CARTESIAN = 1'b1} conv_mode_e;

	typedef struct {
		conv_mode_e         mode;
		logic signed [15:0] x;
		logic signed [15:0] y;
		logic        [14:0] radius;
		logic signed [14:0] angle;
	} coord_pair_t;

	typedef struct packed {
		logic        [15:0] radius;
		logic signed [14:0] angle;
		logic signed [15:0] x;
		logic signed [15:0] y;
	} coord_result_t;

	// Holds predicted conversions in order and checks each item leaving the block
	class conversion_ledger;
		coord_result_t expected_results[$];
		int            errors;

		function new();
			errors = 0;
		endfunction

		static function longint clip(longint v, longint lo, longint hi);
			return (v < lo) ? lo : ((v > hi) ? hi : v);
		endfunction

		// Gain compensation: times K in Q30, drop 46 bits, round half up
		static function longint gain_round(longint v);
			return (v * 64'sd652032874 + (64'sd1 <<< 45)) >>> 46;
		endfunction

		static function coord_result_t cordic_convert(coord_pair_t p);
			longint        atan_step [24];
			longint        cx, cy, cz, t, dx, dy;
			coord_result_t res;
			atan_step = '{188743680, 111421900, 58872272, 29884485, 15000234,
				7507429, 3754631, 1877430, 938729, 469366, 234683, 117342,
				58671, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29};
			res = '0;
			if (p.mode == TO_POLAR) begin
				// Vectoring; the origin gives all zeros
				if (p.x != 0 || p.y != 0) begin
					cx = longint'(p.x) * 65536;
					cy = longint'(p.y) * 65536;
					cz = 0;
					// Left half plane: pre-rotate by 90 degrees toward the right half
					if (cx < 0) begin
						if (cy >= 0) begin
							t = cx; cx = cy; cy = -t; cz = 64'sd5760 * 65536;
						end else begin
							t = cx; cx = -cy; cy = t; cz = -(64'sd5760 * 65536);
						end
					end
					for (int i = 0; i < ROT_USED; i++) begin
						dx = cy >>> i;
						dy = cx >>> i;
						if (cy < 0) begin
							cx -= dx; cy += dy; cz -= atan_step[i];
						end else begin
							cx += dx; cy -= dy; cz += atan_step[i];
						end
					end
					t = clip(gain_round(cx), 0, 65535);
					res.radius = t[15:0];
					t = clip((cz + 32768) >>> 16, -11520, 11520);
					res.angle = t[14:0];
				end
			end else begin
				// Rotation: wrap past +-180, start from (0, +-r) past +-90
				t = longint'(p.angle);
				if (t > 11520) t -= 23040;
				if (t < -11520) t += 23040;
				if (t > 5760) begin
					cx = 0; cy = longint'(p.radius); t -= 5760;
				end else if (t < -5760) begin
					cx = 0; cy = -longint'(p.radius); t += 5760;
				end else begin
					cx = longint'(p.radius); cy = 0;
				end
				cx *= 65536;
				cy *= 65536;
				cz = t * 65536;
				for (int i = 0; i < ROT_USED; i++) begin
					dx = cy >>> i;
					dy = cx >>> i;
					if (cz >= 0) begin
						cx -= dx; cy += dy; cz -= atan_step[i];
					end else begin
						cx += dx; cy -= dy; cz += atan_step[i];
					end
				end
				t = clip(gain_round(cx), -32768, 32767);
				res.x = t[15:0];
				t = clip(gain_round(cy), -32768, 32767);
				res.y = t[15:0];
			end
			return res;
		endfunction

		function void record_pair(coord_pair_t p);
			expected_results.push_back(cordic_convert(p));
		endfunction

		function int outstanding();
			return expected_results.size();
		endfunction

		function void compare_field(string name, longint want, longint got);
			if (want != got) begin
				errors++;
				$display("%0t: %s expected %0d got %0d", $time, name, want, got);
			end
		endfunction

		function void check_result(coord_result_t got);
			coord_result_t want;
			if (expected_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected item radius %0d angle %0d x %0d y %0d",
					$time, got.radius, got.angle, got.x, got.y);
				return;
			end
			want = expected_results.pop_front();
			compare_field("radius_out", longint'(want.radius), longint'(got.radius));
			compare_field("angle_out", longint'(want.angle), longint'(got.angle));
			compare_field("x_out", longint'(want.x), longint'(got.x));
			compare_field("y_out", longint'(want.y), longint'(got.y));
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               mode;
	logic signed [15:0] x_in;
	logic signed [15:0] y_in;
	logic        [14:0] radius_in;
	logic signed [14:0] angle_in;
	logic               out_valid;
	logic               out_ready;
	logic        [15:0] radius_out;
	logic signed [14:0] angle_out;
	logic signed [15:0] x_out;
	logic signed [15:0] y_out;

	conversion_ledger ledger;
	int               idle_pct;
	int               stall_pct;

	polar_cartesian_converter #(.ITERATIONS(ROT_STAGES)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.mode       (mode),
		.x_in       (x_in),
		.y_in       (y_in),
		.radius_in  (radius_in),
		.angle_in   (angle_in),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.radius_out (radius_out),
		.angle_out  (angle_out),
		.x_out      (x_out),
		.y_out      (y_out)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop
	initial begin
		#2ms;
		$display("polar_cartesian_converter_tb: done, errors");
		$finish;
	end

	// Receiver: stall at random per cycle
	initial begin
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			ledger.check_result('{radius_out, angle_out, x_out, y_out});
	end

	function automatic coord_pair_t polar_pair(int xv, int yv);
		coord_pair_t p;
		p = '{TO_POLAR, 16'(xv), 16'(yv), 15'd0, 15'sd0};
		return p;
	endfunction

	function automatic coord_pair_t cart_pair(int rv, int av);
		coord_pair_t p;
		p = '{TO_CARTESIAN, 16'sd0, 16'sd0, 15'(rv), 15'(av)};
		return p;
	endfunction

	// Full-range fields, sometimes small values or range edges
	function automatic coord_pair_t random_pair();
		coord_pair_t p;
		p.mode   = $urandom_range(1) ? TO_CARTESIAN : TO_POLAR;
		p.x      = 16'($urandom);
		p.y      = 16'($urandom);
		p.radius = 15'($urandom);
		p.angle  = 15'($urandom);
		case ($urandom_range(7))
			0: begin
				p.x = 16'(int'($urandom_range(16)) - 8);
				p.y = 16'(int'($urandom_range(16)) - 8);
				p.radius = 15'($urandom_range(8));
			end
			1: begin
				p.radius = 15'h7fff;
				p.angle = $urandom_range(1) ? 15'sd11520 : -15'sd11520;
			end
			2: begin
				p.x = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
				p.y = $urandom_range(1) ? 16'sh8000 : 16'sh7fff;
			end
			default: ;
		endcase
		return p;
	endfunction

	// Offer one item with random idle gaps; returns at the accepting edge
	task automatic push_item(coord_pair_t p);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		mode      <= p.mode;
		x_in      <= p.x;
		y_in      <= p.y;
		radius_in <= p.radius;
		angle_in  <= p.angle;
		in_valid  <= 1'b1;
		do @(posedge clk); while (!in_ready);
		ledger.record_pair(p);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (ledger.outstanding() != 0) @(posedge clk);
	endtask

	int phase_idle [4]  = '{0, 72, 0, 31};
	int phase_stall [4] = '{0, 0, 72, 31};

	initial begin
		ledger    = new();
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		mode      = 1'b0;
		x_in      = '0;
		y_in      = '0;
		radius_in = '0;
		angle_in  = '0;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (10) @(negedge clk);
		arst_n = 1'b1;

		// Directed: origin, axes, corners, quadrants, wrap and half-plane cases
		push_item(polar_pair(0, 0));
		push_item(polar_pair(32767, 0));
		push_item(polar_pair(-32768, 0));
		push_item(polar_pair(-1, 0));
		push_item(polar_pair(0, 32767));
		push_item(polar_pair(0, -32768));
		push_item(polar_pair(-32768, -32768));
		push_item(polar_pair(32767, 32767));
		push_item(polar_pair(-5, 3));
		push_item(polar_pair(-5, -3));
		push_item(polar_pair(1, 1));
		push_item(cart_pair(32767, 0));
		push_item(cart_pair(32767, 11520));
		push_item(cart_pair(32767, -11520));
		push_item(cart_pair(32767, 16383));
		push_item(cart_pair(32767, -16384));
		push_item(cart_pair(32767, 5760));
		push_item(cart_pair(32767, -5760));
		push_item(cart_pair(32767, 5761));
		push_item(cart_pair(32767, -5761));
		push_item(cart_pair(32767, 2880));
		push_item(cart_pair(0, 100));
		push_item(cart_pair(1, -7000));
		wait_drained();

		// Random items across the idle/stall mixes
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = phase_idle[ph];
			stall_pct = phase_stall[ph];
			for (int n = 0; n < 95; n++) begin
				push_item(random_pair());
				// sender holds off once until the pipe is empty
				if (ph == 2 && n == 47)
					wait_drained();
			end
			wait_drained();
		end

		repeat (LATENCY + 10) @(posedge clk);
		if (ledger.errors == 0) begin
			$display("polar_cartesian_converter_tb: done, clean");
		end else begin
			$display("polar_cartesian_converter_tb: done, errors");
		end
		$finish;
	end

endmodule
